@@ hw/rtl/response_stream_deframer_defines.svh @@
// Assertion macros used by the deframer back end.
`ifndef RESPONSE_STREAM_DEFRAMER_DEFINES_SVH
`define RESPONSE_STREAM_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed one cycle later");

`endif

@@ hw/rtl/rsd_pkg.sv @@
// Types, constants and helper functions of the response stream deframer.
`default_nettype none
package rsd_pkg;

   // Field widths fixed by the frame format.
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 6;
   localparam int CFG_W      = 6;
   localparam int CODE_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int RUN_CAP    = 64;
   localparam int FRAME_BYTES_DEF = 64;

   // Frame bytes and limits.
   localparam logic [BYTE_W-1:0] BYTE_START  = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_SECOND = 8'h02;
   localparam logic [BYTE_W-1:0] BYTE_THIRD  = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_INST   = 8'h01;
   localparam logic [BYTE_W-1:0] BYTE_TERM   = 8'h00;
   localparam logic [BYTE_W-1:0] LEN_FLOOR   = 8'h03;
   localparam logic [BYTE_W-1:0] FRAME_EXTRA = 8'h06;
   localparam logic [CFG_W-1:0]  MIN_LEN_RST = 6'h03;
   localparam logic [CFG_W-1:0]  MAX_LEN_RST = 6'h21;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LENGTH = 1'b0,
      CSR_MAX_LENGTH = 1'b1
   } rsd_csr_idx_type;

   // Event codes.
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_STX        = 3'd1,
      ERR_SERVICE    = 3'd2,
      ERR_LENGTH     = 3'd3,
      ERR_INSTANCE   = 3'd4,
      ERR_TERMINATOR = 3'd5,
      ERR_CHECKSUM   = 3'd6
   } rsd_err_type;

   // Parser states, one-hot.
   typedef enum logic [9:0] {
      ST_WAIT     = 10'b00_0000_0001,
      ST_EXP_02   = 10'b00_0000_0010,
      ST_EXP_80   = 10'b00_0000_0100,
      ST_LENGTH   = 10'b00_0000_1000,
      ST_CLASS    = 10'b00_0001_0000,
      ST_EXP_01   = 10'b00_0010_0000,
      ST_ATTR     = 10'b00_0100_0000,
      ST_PAYLOAD  = 10'b00_1000_0000,
      ST_EXP_TERM = 10'b01_0000_0000,
      ST_CHECKSUM = 10'b10_0000_0000
   } rsd_state_type;

   // Store write from the parser.
   typedef struct packed {
      logic              en;
      logic              bank;
      logic [IDX_W-1:0]  idx;
      logic [BYTE_W-1:0] data;
   } rsd_wr_type;

   // One event waiting to be dumped.
   typedef struct packed {
      logic              bank;
      logic [IDX_W-1:0]  count;
      logic              kind;
      rsd_err_type       code;
      logic [BYTE_W-1:0] extra;
      logic [CODE_W-1:0] state;
      logic [BYTE_W-1:0] len;
      logic              len_seen;
      logic              cs_known;
      logic [BYTE_W-1:0] cs_exp;
   } rsd_desc_type;

   // Number of store entries one frame can use.
   function automatic int run_limit(input int frame_bytes);
      return (frame_bytes < RUN_CAP) ? frame_bytes : RUN_CAP;
   endfunction

   // Numeric code of a parser state as reported with an event.
   function automatic logic [CODE_W-1:0] state_code(input rsd_state_type st);
      logic [CODE_W-1:0] c;
      case (st)
         ST_WAIT:     c = 4'd0;
         ST_EXP_02:   c = 4'd1;
         ST_EXP_80:   c = 4'd2;
         ST_LENGTH:   c = 4'd3;
         ST_CLASS:    c = 4'd4;
         ST_EXP_01:   c = 4'd5;
         ST_ATTR:     c = 4'd6;
         ST_PAYLOAD:  c = 4'd7;
         ST_EXP_TERM: c = 4'd8;
         ST_CHECKSUM: c = 4'd9;
         default:     c = 4'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rsd_if.sv @@
// Channel interfaces of the deframer: input bytes, results and register writes.
`default_nettype none
interface rsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [rsd_pkg::BYTE_W-1:0]  rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rsd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        event_kind;
   logic [2:0]                  error_code;
   logic [rsd_pkg::BYTE_W-1:0]  data_byte;
   logic [rsd_pkg::IDX_W-1:0]   byte_index;
   logic                        last;
   logic [rsd_pkg::CODE_W-1:0]  state_at_event;
   logic [rsd_pkg::BYTE_W-1:0]  frame_length;
   logic                        length_known;
   logic [rsd_pkg::BYTE_W-1:0]  checksum_expected;
   logic                        checksum_known;
   logic [rsd_pkg::BYTE_W-1:0]  checksum_received;
   modport source (output valid, output event_kind, output error_code, output data_byte,
                   output byte_index, output last, output state_at_event,
                   output frame_length, output length_known, output checksum_expected,
                   output checksum_known, output checksum_received, input ready);
   modport sink (input valid, input event_kind, input error_code, input data_byte,
                 input byte_index, input last, input state_at_event,
                 input frame_length, input length_known, input checksum_expected,
                 input checksum_known, input checksum_received, output ready);
endinterface

interface rsd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rsd_pkg::CSR_IDX_W-1:0] reg_index;
   logic [rsd_pkg::CFG_W-1:0]     wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rsd_front.sv @@
// Front end: accepts bytes, runs the frame parser, fills the store, queues events.
`default_nettype none
module rsd_front #(
   parameter int FRAME_BYTES = rsd_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rsd_req_if.sink                    req,
   rsd_csr_if.sink                    csr,
   input  wire logic                  q_full,
   output logic                       push,
   output rsd_pkg::rsd_desc_type      desc,
   output rsd_pkg::rsd_wr_type        wr
);
   import rsd_pkg::*;

   localparam int RunLimit = run_limit(FRAME_BYTES);

   rsd_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic              seen_ff, seen_in;
   logic [IDX_W-1:0]  pexp_ff, pexp_in;
   logic [IDX_W-1:0]  prcv_ff, prcv_in;
   logic              bank_ff, bank_in;
   logic [CFG_W-1:0]  min_ff, min_in;
   logic [CFG_W-1:0]  max_ff, max_in;

   logic              accept;
   logic [BYTE_W-1:0] b;
   logic              keep;
   logic              err;
   logic              good;
   rsd_err_type       code;
   logic              len_bad;
   logic [IDX_W-1:0]  prcv_inc;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign csr.ready = 1'b1;
   assign prcv_inc  = prcv_ff + 1'b1;

   // Length byte checks against the fixed floor, the registers and the store size.
   assign len_bad = (b < LEN_FLOOR) || (b < {2'b00, min_ff}) || (b > {2'b00, max_ff}) ||
                    (({1'b0, b} + {1'b0, FRAME_EXTRA}) > 9'(RunLimit));

   // Parser decision for the accepted word.
   always_comb begin
      keep  = 1'b0;
      err   = 1'b0;
      good  = 1'b0;
      code  = ERR_NONE;
      state_in = state_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      pexp_in  = pexp_ff;
      prcv_in  = prcv_ff;
      if (accept) begin
         case (state_ff)
            ST_WAIT: begin
               if (b == BYTE_START) begin
                  keep     = 1'b1;
                  state_in = ST_EXP_02;
               end
            end
            ST_EXP_02: begin
               if (b != BYTE_SECOND) begin
                  err  = 1'b1;
                  code = ERR_STX;
               end else begin
                  keep     = 1'b1;
                  state_in = ST_EXP_80;
               end
            end
            ST_EXP_80: begin
               if (b != BYTE_THIRD) begin
                  err  = 1'b1;
                  code = ERR_SERVICE;
               end else begin
                  keep     = 1'b1;
                  state_in = ST_LENGTH;
               end
            end
            ST_LENGTH: begin
               if (len_bad) begin
                  err  = 1'b1;
                  code = ERR_LENGTH;
               end else begin
                  keep     = 1'b1;
                  len_in   = b;
                  seen_in  = 1'b1;
                  pexp_in  = IDX_W'(b - LEN_FLOOR);
                  prcv_in  = '0;
                  state_in = ST_CLASS;
               end
            end
            ST_CLASS: begin
               keep     = 1'b1;
               state_in = ST_EXP_01;
            end
            ST_EXP_01: begin
               if (b != BYTE_INST) begin
                  err  = 1'b1;
                  code = ERR_INSTANCE;
               end else begin
                  keep     = 1'b1;
                  state_in = ST_ATTR;
               end
            end
            ST_ATTR: begin
               keep     = 1'b1;
               state_in = (pexp_ff == '0) ? ST_EXP_TERM : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               keep    = 1'b1;
               prcv_in = prcv_inc;
               if (prcv_inc >= pexp_ff) begin
                  state_in = ST_EXP_TERM;
               end
            end
            ST_EXP_TERM: begin
               if (b != BYTE_TERM) begin
                  err  = 1'b1;
                  code = ERR_TERMINATOR;
               end else begin
                  keep     = 1'b1;
                  state_in = ST_CHECKSUM;
               end
            end
            ST_CHECKSUM: begin
               if (b != sum_ff) begin
                  err  = 1'b1;
                  code = ERR_CHECKSUM;
               end else begin
                  good = 1'b1;
               end
            end
            default: begin
               state_in = (b == BYTE_START) ? ST_EXP_02 : ST_WAIT;
               keep     = (b == BYTE_START);
            end
         endcase
      end
   end

   // Store writes, running sum and event hand-off to the queue.
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      bank_in  = bank_ff;
      push     = err || good;
      wr.en    = keep;
      wr.bank  = bank_ff;
      wr.idx   = count_ff;
      wr.data  = b;
      desc.bank     = bank_ff;
      desc.count    = count_ff;
      desc.kind     = err;
      desc.code     = code;
      desc.extra    = b;
      desc.state    = state_code(state_ff);
      desc.len      = len_ff;
      desc.len_seen = seen_ff;
      desc.cs_known = good || (code == ERR_CHECKSUM);
      desc.cs_exp   = sum_ff;
      if (keep) begin
         count_in = count_ff + 1'b1;
         sum_in   = sum_ff + b;
      end
      if (err || good) begin
         // The event owns this bank now; the next frame goes to the other one.
         bank_in  = !bank_ff;
         count_in = '0;
         sum_in   = '0;
         // A zero offending byte opens the next frame. Entry zero of every frame is
         // the start byte, which the back end supplies itself, so the other bank,
         // possibly still being dumped, is left untouched.
         if (err && (b == BYTE_START)) begin
            count_in = IDX_W'(1);
         end
      end
   end

   // Configuration register writes.
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr.valid && csr.ready) begin
         case (rsd_csr_idx_type'(csr.reg_index))
            CSR_MIN_LENGTH: min_in = csr.wr_data;
            CSR_MAX_LENGTH: max_in = csr.wr_data;
            default: begin
               min_in = min_ff;
               max_in = max_ff;
            end
         endcase
      end
   end

   // Parser registers; an event clears the frame and may restart on a start byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         count_ff <= '0;
         sum_ff   <= '0;
         len_ff   <= '0;
         seen_ff  <= 1'b0;
         pexp_ff  <= '0;
         prcv_ff  <= '0;
         bank_ff  <= 1'b0;
         min_ff   <= MIN_LEN_RST;
         max_ff   <= MAX_LEN_RST;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         bank_ff  <= bank_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         if (err || good) begin
            state_ff <= (err && (b == BYTE_START)) ? ST_EXP_02 : ST_WAIT;
            len_ff   <= '0;
            seen_ff  <= 1'b0;
            pexp_ff  <= '0;
            prcv_ff  <= '0;
         end else begin
            state_ff <= state_in;
            len_ff   <= len_in;
            seen_ff  <= seen_in;
            pexp_ff  <= pexp_in;
            prcv_ff  <= prcv_in;
         end
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/rsd_evq.sv @@
// Two-entry event queue between the parser and the dump engine.
`default_nettype none
module rsd_evq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  rsd_pkg::rsd_desc_type      push_desc,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       head_valid,
   output rsd_pkg::rsd_desc_type      head
);
   import rsd_pkg::*;

   rsd_desc_type entries_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/rsd_back.sv @@
// Back end: holds the two-bank frame store and dumps each queued event word by word.
`default_nettype none
`include "response_stream_deframer_defines.svh"
module rsd_back #(
   parameter int FRAME_BYTES = rsd_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  rsd_pkg::rsd_wr_type        wr,
   input  wire logic                  head_valid,
   input  rsd_pkg::rsd_desc_type      head,
   output logic                       pop,
   rsd_rsp_if.source                  rsp
);
   import rsd_pkg::*;

   localparam int RunLimit = run_limit(FRAME_BYTES);
   localparam int Depth    = 2 * RunLimit;
   localparam int AddrW    = $clog2(Depth);

   logic [BYTE_W-1:0] store_mem [Depth];

   logic [IDX_W-1:0]  k_ff, k_in;
   logic              rd_pend_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              issue;
   logic              fin;
   logic [AddrW-1:0]  waddr;
   logic [AddrW-1:0]  raddr;

   logic              valid_ff, valid_in;
   logic              kind_ff;
   logic [2:0]        code_ff;
   logic [BYTE_W-1:0] data_ff;
   logic [IDX_W-1:0]  index_ff;
   logic              last_ff;
   logic [CODE_W-1:0] state_ff;
   logic [BYTE_W-1:0] flen_ff;
   logic              lknown_ff;
   logic [BYTE_W-1:0] csexp_ff;
   logic              csknown_ff;
   logic [BYTE_W-1:0] csrx_ff;

   // Bank one sits right after bank zero in the store.
   assign waddr = wr.bank ? (AddrW'(wr.idx) + AddrW'(RunLimit)) : AddrW'(wr.idx);
   assign raddr = head.bank ? (AddrW'(k_ff) + AddrW'(RunLimit)) : AddrW'(k_ff);

   // A read is issued only when the output register will be free when its data lands.
   assign issue = head_valid && !rd_pend_ff && (!valid_ff || rsp.ready);
   assign fin   = (rd_idx_ff == head.count);
   assign pop   = rd_pend_ff && fin;
   assign k_in  = issue ? ((k_ff == head.count) ? '0 : k_ff + 1'b1) : k_ff;
   assign valid_in = rd_pend_ff || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[waddr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= store_mem[raddr];
         rd_idx_ff  <= k_ff;
      end
   end

   // Dump sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= '0;
         rd_pend_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         k_ff       <= k_in;
         rd_pend_ff <= issue;
         valid_ff   <= valid_in;
      end
   end

   // Output word; summary fields go only on the final word.
   // Every frame opens with the start byte, so word zero never comes from the store.
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         kind_ff    <= head.kind;
         code_ff    <= head.code;
         data_ff    <= fin ? head.extra : ((rd_idx_ff == '0) ? BYTE_START : rd_data_ff);
         index_ff   <= rd_idx_ff;
         last_ff    <= fin;
         state_ff   <= head.state;
         flen_ff    <= (fin && head.len_seen) ? head.len : '0;
         lknown_ff  <= fin && head.len_seen;
         csexp_ff   <= (fin && head.cs_known) ? head.cs_exp : '0;
         csknown_ff <= fin && head.cs_known;
         csrx_ff    <= (fin && head.cs_known) ? head.extra : '0;
      end
   end

   assign rsp.valid             = valid_ff;
   assign rsp.event_kind        = kind_ff;
   assign rsp.error_code        = code_ff;
   assign rsp.data_byte         = data_ff;
   assign rsp.byte_index        = index_ff;
   assign rsp.last              = last_ff;
   assign rsp.state_at_event    = state_ff;
   assign rsp.frame_length      = flen_ff;
   assign rsp.length_known      = lknown_ff;
   assign rsp.checksum_expected = csexp_ff;
   assign rsp.checksum_known    = csknown_ff;
   assign rsp.checksum_received = csrx_ff;

   // A landing read never meets a full output register.
   `RSD_ASSERT_NOW(a_land_free, clock, reset, rd_pend_ff, !valid_ff)
   // An event is retired only while one is queued.
   `RSD_ASSERT_NOW(a_pop_head, clock, reset, pop, head_valid)
   // Retiring an event shows its final word next cycle.
   `RSD_ASSERT_NEXT(a_pop_last, clock, reset, pop, valid_ff && last_ff)

endmodule
`default_nettype wire

@@ hw/rtl/response_stream_deframer.sv @@
// Top level of the response stream deframer.
`default_nettype none
// Takes one received byte per word on req_chan and recognizes response frames of the form
// 00 02 80 length class 01 attribute payload 00 checksum. A good frame, or a byte that
// breaks the format, produces an event of count+1 result words on rsp_chan, the final
// word carrying the summary fields. Input bytes are taken one per cycle while the
// two-entry event queue has room; each queued event owns one bank of the two-bank frame
// store, so input stalls only while two events wait to be dumped. Store reads are
// registered ahead of the output register, one in flight at a time. The user must write
// length limits on csr_chan while the block is idle; the block does not enforce this.
module response_stream_deframer #(
   parameter int FRAME_BYTES = rsd_pkg::FRAME_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rsd_req_if.sink    req_chan,
   rsd_rsp_if.source  rsp_chan,
   rsd_csr_if.sink    csr_chan
);
   import rsd_pkg::*;

   logic         q_full;
   logic         push;
   logic         pop;
   logic         head_valid;
   rsd_desc_type push_desc;
   rsd_desc_type head;
   rsd_wr_type   wr;

   rsd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .csr    (csr_chan),
      .q_full (q_full),
      .push   (push),
      .desc   (push_desc),
      .wr     (wr)
   );

   rsd_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   rsd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
`default_nettype wire

@@ sim/tb_response_stream_deframer.sv @@
// Self-checking testbench of the response stream deframer: directed bytes, then random frames.
`default_nettype none
module tb_response_stream_deframer;

   // Frame size parameter of the block as built, and the entries that one frame may use.
   localparam int FRAME_BYTES = rsd_pkg::FRAME_BYTES_DEF;
   localparam int STORE_LIMIT = (FRAME_BYTES < 64) ? FRAME_BYTES : 64;
   localparam int PHASE_ITEMS = 25;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 50;

   // Parser states as reported in state_at_event.
   typedef enum logic [3:0] {
      PS_WAIT      = 4'd0,
      PS_EXP_02    = 4'd1,
      PS_EXP_80    = 4'd2,
      PS_LENGTH    = 4'd3,
      PS_CLASS     = 4'd4,
      PS_EXP_01    = 4'd5,
      PS_ATTR      = 4'd6,
      PS_PAYLOAD   = 4'd7,
      PS_EXP_TERM  = 4'd8,
      PS_CHECKSUM  = 4'd9
   } parse_state_type;

   // One result word as the block should emit it.
   typedef struct packed {
      logic       kind;
      logic [2:0] code;
      logic [7:0] data;
      logic [5:0] idx;
      logic       last;
      logic [3:0] st;
      logic [7:0] flen;
      logic       lk;
      logic [7:0] cexp;
      logic       ck;
      logic [7:0] crx;
   } rsp_word_type;

   // One row of the directed table; typed rows give the final word of the event they cause.
   typedef struct packed {
      logic [7:0]           rx;
      logic                 typed;
      logic                 kind;
      rsd_pkg::rsd_err_type code;
      parse_state_type      st;
      logic [7:0]           data;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsd_req_if req_bus ();
   rsd_rsp_if rsp_bus ();
   rsd_csr_if csr_bus ();

   response_stream_deframer #(
      .FRAME_BYTES (FRAME_BYTES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Deframer state as predicted from the accepted words.
   parse_state_type ps = PS_WAIT;
   logic [7:0]   frame_buf [STORE_LIMIT];
   int           fill_count = 0;
   logic [7:0]   sum_acc = 8'h00;
   logic [7:0]   len_val = 8'h00;
   logic         len_seen = 1'b0;
   logic [5:0]   pay_want = 6'd0;
   logic [5:0]   pay_got = 6'd0;
   logic [5:0]   cfg_min = rsd_pkg::MIN_LEN_RST;
   logic [5:0]   cfg_max = rsd_pkg::MAX_LEN_RST;

   rsp_word_type pending_words [$];
   int           words_predicted = 0;
   int           items_counted = 0;
   int           fail_count = 0;
   bit           snd_quiet = 1'b0;
   bit           rcv_quiet = 1'b0;

   dir_row_type dir_tab [25] = '{
      '{8'h55, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'hff, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h00, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h03, 1'b1, 1'b1, rsd_pkg::ERR_STX,        PS_EXP_02,   8'h03},
      '{8'h00, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h02, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h7f, 1'b1, 1'b1, rsd_pkg::ERR_SERVICE,    PS_EXP_80,   8'h7f},
      '{8'h00, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h02, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h80, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h02, 1'b1, 1'b1, rsd_pkg::ERR_LENGTH,     PS_LENGTH,   8'h02},
      '{8'h00, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h02, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h80, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h03, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'haa, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h00, 1'b1, 1'b1, rsd_pkg::ERR_INSTANCE,   PS_EXP_01,   8'h00},
      '{8'h02, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h80, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h03, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h55, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h01, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'hff, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'h00, 1'b0, 1'b0, rsd_pkg::ERR_NONE,       PS_WAIT,     8'h00},
      '{8'hda, 1'b1, 1'b0, rsd_pkg::ERR_NONE,       PS_CHECKSUM, 8'hda}
   };

   // Length limits of the random phases; the crossed pair rejects every length.
   logic [5:0] plan_min [7] = '{6'd3,  6'd3,  6'd58, 6'd10, 6'd40, 6'd0,  6'd3};
   logic [5:0] plan_max [7] = '{6'd58, 6'd33, 6'd58, 6'd20, 6'd10, 6'd63, 6'd3};

   // Clock with a period of four units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Frame state goes back to waiting for a start byte.
   function automatic void restart_frame();
      ps = PS_WAIT;
      fill_count = 0;
      sum_acc = 8'h00;
      len_val = 8'h00;
      len_seen = 1'b0;
      pay_want = 6'd0;
      pay_got = 6'd0;
   endfunction

   function automatic void store_byte(input logic [7:0] b);
      if (fill_count < STORE_LIMIT) begin
         frame_buf[fill_count] = b;
         fill_count++;
         sum_acc = sum_acc + b;
      end
   endfunction

   // Queues the words of one event: the stored bytes, then the offending byte if any.
   function automatic void queue_event(input logic kind, input rsd_pkg::rsd_err_type code,
                                       input bit with_extra, input logic [7:0] extra,
                                       input bit cs_known, input logic [7:0] cs_exp,
                                       input logic [7:0] cs_rx);
      int           n;
      bit           fin;
      rsp_word_type w;
      n = fill_count + (with_extra ? 1 : 0);
      if (n > 64)
         n = 64;
      for (int k = 0; k < n; k++) begin
         fin = (k == n - 1);
         w.kind = kind;
         w.code = code;
         w.data = (with_extra && fin) ? extra : frame_buf[k];
         w.idx = 6'(k);
         w.last = fin;
         w.st = ps;
         w.flen = (fin && len_seen) ? len_val : 8'h00;
         w.lk = fin && len_seen;
         w.cexp = (fin && cs_known) ? cs_exp : 8'h00;
         w.ck = fin && cs_known;
         w.crx = (fin && cs_known) ? cs_rx : 8'h00;
         pending_words.push_back(w);
         words_predicted++;
      end
   endfunction

   // A broken expectation dumps the frame; a zero offending byte opens the next frame.
   function automatic void reject_byte(input rsd_pkg::rsd_err_type code, input logic [7:0] b,
                                       input bit cs_known, input logic [7:0] cs_exp);
      queue_event(1'b1, code, 1'b1, b, cs_known, cs_exp, b);
      restart_frame();
      if (b == rsd_pkg::BYTE_START) begin
         store_byte(b);
         ps = PS_EXP_02;
      end
   endfunction

   // Advances the predicted parser by one received byte.
   function automatic void deframe_byte(input logic [7:0] b);
      logic [7:0] want;
      case (ps)
         PS_EXP_02: begin
            if (b != rsd_pkg::BYTE_SECOND) reject_byte(rsd_pkg::ERR_STX, b, 1'b0, 8'h00);
            else begin
               store_byte(b);
               ps = PS_EXP_80;
            end
         end
         PS_EXP_80: begin
            if (b != rsd_pkg::BYTE_THIRD) reject_byte(rsd_pkg::ERR_SERVICE, b, 1'b0, 8'h00);
            else begin
               store_byte(b);
               ps = PS_LENGTH;
            end
         end
         PS_LENGTH: begin
            if (b < rsd_pkg::LEN_FLOOR || b < {2'b00, cfg_min} || b > {2'b00, cfg_max} ||
                int'(b) + 6 > STORE_LIMIT) begin
               reject_byte(rsd_pkg::ERR_LENGTH, b, 1'b0, 8'h00);
            end else begin
               len_val = b;
               len_seen = 1'b1;
               pay_want = 6'(b - rsd_pkg::LEN_FLOOR);
               pay_got = 6'd0;
               store_byte(b);
               ps = PS_CLASS;
            end
         end
         PS_CLASS: begin
            store_byte(b);
            ps = PS_EXP_01;
         end
         PS_EXP_01: begin
            if (b != rsd_pkg::BYTE_INST) reject_byte(rsd_pkg::ERR_INSTANCE, b, 1'b0, 8'h00);
            else begin
               store_byte(b);
               ps = PS_ATTR;
            end
         end
         PS_ATTR: begin
            store_byte(b);
            ps = (pay_want == 6'd0) ? PS_EXP_TERM : PS_PAYLOAD;
         end
         PS_PAYLOAD: begin
            store_byte(b);
            pay_got = pay_got + 6'd1;
            if (pay_got >= pay_want)
               ps = PS_EXP_TERM;
         end
         PS_EXP_TERM: begin
            if (b != rsd_pkg::BYTE_TERM) reject_byte(rsd_pkg::ERR_TERMINATOR, b, 1'b0, 8'h00);
            else begin
               store_byte(b);
               ps = PS_CHECKSUM;
            end
         end
         PS_CHECKSUM: begin
            want = sum_acc;
            if (b != want) reject_byte(rsd_pkg::ERR_CHECKSUM, b, 1'b1, want);
            else begin
               store_byte(b);
               queue_event(1'b0, rsd_pkg::ERR_NONE, 1'b0, 8'h00, 1'b1, want, b);
               restart_frame();
            end
         end
         default: begin
            restart_frame();
            if (b == rsd_pkg::BYTE_START) begin
               store_byte(b);
               ps = PS_EXP_02;
            end
         end
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Compares one result word with the oldest expected word.
   task automatic check_word();
      rsp_word_type w;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected word, expected none actual data %0h", $time,
                  rsp_bus.data_byte);
         fail_count++;
      end else begin
         w = pending_words.pop_front();
         compare_field("event_kind", w.kind, rsp_bus.event_kind);
         compare_field("error_code", w.code, rsp_bus.error_code);
         compare_field("data_byte", w.data, rsp_bus.data_byte);
         compare_field("byte_index", w.idx, rsp_bus.byte_index);
         compare_field("last", w.last, rsp_bus.last);
         compare_field("state_at_event", w.st, rsp_bus.state_at_event);
         compare_field("frame_length", w.flen, rsp_bus.frame_length);
         compare_field("length_known", w.lk, rsp_bus.length_known);
         compare_field("checksum_expected", w.cexp, rsp_bus.checksum_expected);
         compare_field("checksum_known", w.ck, rsp_bus.checksum_known);
         compare_field("checksum_received", w.crx, rsp_bus.checksum_received);
      end
   endtask

   // All handshakes are observed at the rising edge: results first, then writes and bytes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_word();
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.reg_index == rsd_pkg::CSR_MIN_LENGTH)
               cfg_min = csr_bus.wr_data;
            else
               cfg_max = csr_bus.wr_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            items_counted++;
            deframe_byte(req_bus.rx_byte);
         end
      end
   end

   // Sends one byte word after a random gap; returns at the falling edge after acceptance.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 15) == 0)
         snd_quiet = !snd_quiet;
      gap = snd_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   // Holds the input off until every expected word has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_words.size() != 0);
   endtask

   task automatic write_csr(input rsd_pkg::rsd_csr_idx_type idx, input logic [5:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_limits(input logic [5:0] lo, input logic [5:0] hi);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(rsd_pkg::CSR_MIN_LENGTH, lo);
      write_csr(rsd_pkg::CSR_MAX_LENGTH, hi);
   endtask

   // Builds one frame with random content, sometimes damaged, and sends it.
   task automatic send_random_frame();
      logic [7:0] tx_q [$];
      logic [7:0] sum;
      int         lo;
      int         hi;
      int         len;
      int         npay;
      int         pick;
      int         noise;
      lo = (cfg_min < 3) ? 3 : int'(cfg_min);
      hi = (cfg_max > 58) ? 58 : int'(cfg_max);
      pick = $urandom_range(0, 99);
      if (lo > hi) len = $urandom_range(0, 63);
      else if (pick < 70) len = $urandom_range(lo, (lo + 8 < hi) ? lo + 8 : hi);
      else if (pick < 80) len = hi;
      else if (pick < 85) len = lo;
      else if (pick < 95) len = $urandom_range(0, 63);
      else len = $urandom_range(0, 255);
      npay = (len >= 3 && len <= 58) ? len - 3 : 2;
      tx_q = '{rsd_pkg::BYTE_START, rsd_pkg::BYTE_SECOND, rsd_pkg::BYTE_THIRD, 8'(len),
               8'($urandom_range(0, 255)), rsd_pkg::BYTE_INST, 8'($urandom_range(0, 255))};
      for (int i = 0; i < npay; i++)
         tx_q.push_back(8'($urandom_range(0, 255)));
      tx_q.push_back(rsd_pkg::BYTE_TERM);
      sum = 8'h00;
      foreach (tx_q[i])
         sum = sum + tx_q[i];
      tx_q.push_back(sum);
      // A damaged byte exercises every error path, including the checksum.
      if ($urandom_range(0, 4) == 0)
         tx_q[$urandom_range(1, tx_q.size() - 1)] = 8'($urandom_range(0, 255));
      // Line noise between frames; a zero here starts a frame early.
      if ($urandom_range(0, 3) == 0) begin
         noise = $urandom_range(1, 3);
         repeat (noise) push_byte(8'($urandom_range(0, 255)));
      end
      foreach (tx_q[i])
         push_byte(tx_q[i]);
   endtask

   // Result side: a random stall before each word, with stretches of none.
   initial begin
      int w;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rcv_quiet = !rcv_quiet;
         w = rcv_quiet ? 0 : $urandom_range(0, 8);
         if (w > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         @(negedge clock);
      end
   end

   // Stimulus: directed table at reset limits, then random phases over several limit pairs.
   initial begin
      int           words_before;
      int           start;
      int           frame_no;
      rsp_word_type tail;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'h00;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = rsd_pkg::CSR_MIN_LENGTH;
      csr_bus.wr_data = 6'd0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i]) begin
         words_before = words_predicted;
         push_byte(dir_tab[i].rx);
         if (dir_tab[i].typed) begin
            if (words_predicted == words_before) begin
               $display("%0t: row %0d expected an event actual none", $time, i);
               fail_count++;
            end else begin
               tail = pending_words[$];
               if ({tail.kind, tail.code, tail.st, tail.data} !==
                   {dir_tab[i].kind, dir_tab[i].code, dir_tab[i].st, dir_tab[i].data}) begin
                  $display("%0t: row %0d expected %0h/%0h/%0h/%0h actual %0h/%0h/%0h/%0h",
                           $time, i, dir_tab[i].kind, dir_tab[i].code, dir_tab[i].st,
                           dir_tab[i].data, tail.kind, tail.code, tail.st, tail.data);
                  fail_count++;
               end
            end
         end
      end

      frame_no = 0;
      foreach (plan_min[p]) begin
         apply_limits(plan_min[p], plan_max[p]);
         start = items_counted;
         while (items_counted - start < PHASE_ITEMS) begin
            // Now and then the sender waits until all results are out.
            if (frame_no % 6 == 3)
               wait_drained();
            send_random_frame();
            frame_no++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("** response_stream_deframer: PASSED **");
      else
         $display("** response_stream_deframer: FAILED **");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10000000;
      $display("** response_stream_deframer: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

@@ response_stream_deframer.f @@
+incdir+hw/rtl
hw/rtl/rsd_pkg.sv
hw/rtl/rsd_if.sv
hw/rtl/rsd_front.sv
hw/rtl/rsd_evq.sv
hw/rtl/rsd_back.sv
hw/rtl/response_stream_deframer.sv
sim/tb_response_stream_deframer.sv
